// ----- hw/rtl/kpne_pkg.sv -----
// Shared types, codes and the keypad layout table for the keypad number entry scanner.
// No dependencies; every other file but kpne_req_if imports this package.
package kpne_pkg;

   localparam int MAX_DIGITS_DEF = 3;
   localparam int LOCK_W         = 20;
   localparam int NUM_W          = 10;
   localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 20'd250000;

   // Key codes: digits are 0..9, then the two command keys
   localparam logic [3:0] KEY_CLEAR = 4'd10;
   localparam logic [3:0] KEY_ENTER = 4'd11;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_NUMBER = 2'd1,
      EV_CANCEL = 2'd2,
      EV_ABORT  = 2'd3
   } event_type;

   typedef struct packed {
      logic [1:0]       row_drive;
      event_type        event_res;
      logic [NUM_W-1:0] number;
      logic [1:0]       digit_count;
   } rsp_type;

   // Layout, top row first: 1 2 3 / 4 5 6 / 7 8 9 / A 0 P
   function automatic logic [3:0] key_lut(input logic [1:0] row, input logic [1:0] col);
      logic [3:0] key;
      unique case ({row, col})
         4'b00_00: key = 4'd1;
         4'b00_01: key = 4'd2;
         4'b01_00: key = 4'd4;
         4'b01_01: key = 4'd5;
         4'b01_10: key = 4'd6;
         4'b10_00: key = 4'd7;
         4'b10_01: key = 4'd8;
         4'b10_10: key = 4'd9;
         4'b11_00: key = KEY_CLEAR;
         4'b11_01: key = 4'd0;
         4'b11_10: key = KEY_ENTER;
         default:  key = 4'd3;
      endcase
      return key;
   endfunction

endpackage

// ----- hw/rtl/kpne_req_if.sv -----
// Request channel of the keypad scanner: valid/ready plus one column sample and abort.
// No dependencies.
interface kpne_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] column_lines;
   logic       abort;

   modport source (output valid, output column_lines, output abort, input ready);
   modport sink   (input valid, input column_lines, input abort, output ready);
endinterface

// ----- hw/rtl/kpne_rsp_if.sv -----
// Response channel of the keypad scanner: valid/ready plus row, event, number, count.
// Depends on kpne_pkg.
interface kpne_rsp_if
   import kpne_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [1:0]       row_drive;
   logic [1:0]       event_res;
   logic [NUM_W-1:0] number;
   logic [1:0]       digit_count;

   modport source (output valid, output row_drive, output event_res, output number,
                   output digit_count, input ready);
   modport sink   (input valid, input row_drive, input event_res, input number,
                   input digit_count, output ready);
endinterface

// ----- hw/rtl/keypad_number_entry_scanner.sv -----
// Top level of the 4x3 keypad scanner with decimal number entry.
// Depends on kpne_pkg, kpne_req_if, kpne_rsp_if, kpne_scan_core, kpne_out_reg.
//
//   channel   | direction | carries
//   ----------+-----------+-------------------------------------------
//   req_chan  | in        | column_lines[2:0], abort
//   rsp_chan  | out       | row_drive[1:0], event_res[1:0], number, digit_count
//   csr_*     | in        | lockout_ticks write (csr_we, csr_wdata[19:0])
//
// One request per clock while the output register has space; its response is in the output register on the next cycle.
// The scan state updates in the accept cycle, so back-to-back requests see it at once.
// A stalled response holds req_chan.ready low only while the output register stays full.
// Synchronous reset: row 0, no lockout, empty entry, lockout_ticks = 250000.
module keypad_number_entry_scanner
   import kpne_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [LOCK_W-1:0] csr_wdata,
   kpne_req_if.sink          req_chan,
   kpne_rsp_if.source        rsp_chan
);

   logic    space;
   logic    take;
   rsp_type result;

   assign req_chan.ready = space;
   assign take           = req_chan.valid && space;

   kpne_scan_core #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .take         (take),
      .column_lines (req_chan.column_lines),
      .abort        (req_chan.abort),
      .result       (result)
   );

   kpne_out_reg u_out (
      .clock (clock),
      .reset (reset),
      .load  (take),
      .data  (result),
      .space (space),
      .rsp   (rsp_chan)
   );

endmodule

// ----- hw/rtl/kpne_scan_core.sv -----
// Scan state (row, lockout, entry accumulator) and the per-request update logic.
// Depends on kpne_pkg.
module kpne_scan_core
   import kpne_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [LOCK_W-1:0] csr_wdata,
   input  logic              take,
   input  logic [2:0]        column_lines,
   input  logic              abort,
   output rsp_type           result
);

   localparam int HELD_W = $clog2(MAX_DIGITS + 1);
   localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(MAX_DIGITS);

   logic [LOCK_W-1:0] lockout_ticks_ff, lockout_ticks_in;
   logic [LOCK_W-1:0] lock_cnt_ff, lock_cnt_in;
   logic [1:0]        row_ff, row_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [NUM_W-1:0]  acc_ff, acc_in;
   logic [1:0]        col;
   logic [3:0]        key;
   event_type         ev;
   logic [NUM_W-1:0]  value;
   logic [31:0]       held_wide;

   assign lockout_ticks_in = csr_we ? csr_wdata : lockout_ticks_ff;

   always_comb begin
      priority if (column_lines[0]) col = 2'd0;
      else if (column_lines[1])     col = 2'd1;
      else                          col = 2'd2;
   end

   assign key = key_lut(row_ff, col);

   always_comb begin
      row_in      = row_ff;
      lock_cnt_in = lock_cnt_ff;
      held_in     = held_ff;
      acc_in      = acc_ff;
      ev          = EV_NONE;
      value       = '0;
      priority if (abort) begin
         ev          = EV_ABORT;
         held_in     = '0;
         acc_in      = '0;
         lock_cnt_in = '0;
         row_in      = 2'd0;
      end else if (lock_cnt_ff != '0) begin
         lock_cnt_in = lock_cnt_ff - 1'b1;
      end else if (column_lines != 3'b000) begin
         row_in      = 2'd0;
         lock_cnt_in = lockout_ticks_ff;
         // a digit key on a full entry matches no arm and is dropped
         if (key == KEY_ENTER) begin
            ev      = EV_NUMBER;
            value   = acc_ff;
            held_in = '0;
            acc_in  = '0;
         end else if (key == KEY_CLEAR) begin
            if (held_ff == '0) begin
               ev = EV_CANCEL;
            end
            held_in = '0;
            acc_in  = '0;
         end else if (held_ff < HELD_MAX) begin
            // running value mod 1024: acc*10 + key
            acc_in  = NUM_W'({acc_ff, 3'b000}) + NUM_W'({acc_ff, 1'b0}) + NUM_W'(key);
            held_in = held_ff + 1'b1;
         end
      end else begin
         row_in = row_ff + 2'd1;
      end
   end

   assign held_wide          = 32'(held_in);
   assign result.row_drive   = row_in;
   assign result.event_res   = ev;
   assign result.number      = value;
   assign result.digit_count = held_wide[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_RESET;
         lock_cnt_ff      <= '0;
         row_ff           <= 2'd0;
         held_ff          <= '0;
         acc_ff           <= '0;
      end else begin
         lockout_ticks_ff <= lockout_ticks_in;
         if (take) begin
            lock_cnt_ff <= lock_cnt_in;
            row_ff      <= row_in;
            held_ff     <= held_in;
            acc_ff      <= acc_in;
         end
      end
   end

endmodule

// ----- hw/rtl/kpne_out_reg.sv -----
// Response register: holds one finished response and frees as it is taken.
// Depends on kpne_pkg and kpne_rsp_if.
module kpne_out_reg
   import kpne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  rsp_type    data,
   output logic       space,
   kpne_rsp_if.source rsp
);

   logic    full_ff, full_in;
   rsp_type data_ff, data_in;

   assign space   = !full_ff || rsp.ready;
   assign full_in = load || (full_ff && !rsp.ready);
   assign data_in = load ? data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid       = full_ff;
   assign rsp.row_drive   = data_ff.row_drive;
   assign rsp.event_res   = data_ff.event_res;
   assign rsp.number      = data_ff.number;
   assign rsp.digit_count = data_ff.digit_count;

endmodule

// ----- hw/rtl/kpne_checker.sv -----
// Port-level checks for the keypad scanner, attached to the top level by bind.
// Depends on kpne_pkg and keypad_number_entry_scanner.
module kpne_checker
   import kpne_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_abort,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_row_drive,
   input logic [1:0]       rsp_event_res,
   input logic [NUM_W-1:0] rsp_number,
   input logic [1:0]       rsp_digit_count
);

   // an abort always lands as the next response with a cleared entry
   a_abort_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_abort |=>
         rsp_valid && rsp_event_res == EV_ABORT && rsp_digit_count == 2'd0
         && rsp_row_drive == 2'd0)
      else $error("abort request did not produce an abort response");

   a_clear_after_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_NUMBER || rsp_event_res == EV_CANCEL) |->
         rsp_digit_count == 2'd0 && rsp_row_drive == 2'd0)
      else $error("entry not cleared on enter or cancel");

   a_number_only_on_enter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_NUMBER |-> rsp_number == '0)
      else $error("number nonzero outside a number event");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_number) && $stable(rsp_digit_count) && $stable(rsp_row_drive))
      else $error("stalled response changed");

endmodule

bind keypad_number_entry_scanner kpne_checker u_kpne_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_abort       (req_chan.abort),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_row_drive   (rsp_chan.row_drive),
   .rsp_event_res   (rsp_chan.event_res),
   .rsp_number      (rsp_chan.number),
   .rsp_digit_count (rsp_chan.digit_count)
);
